@@ sv/abl_pkg.sv @@
// Shared types and constants for the additive alpha pixel blend block.
package abl_pkg;

    localparam int CHAN_W     = 8;
    localparam int NUM_W      = 2 * CHAN_W;
    localparam int NCH        = 3;
    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = CHAN_W / DIV_BITS;

    localparam logic [CHAN_W-1:0] ALPHA_MAX = 8'd255;

    localparam int CH_BLUE  = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_RED   = 2;

    typedef logic [CHAN_W-1:0]           t_chan;
    typedef logic [NUM_W-1:0]            t_num;
    typedef logic [NCH-1:0][CHAN_W-1:0]  t_rgb;

    typedef struct packed {
        t_chan da;
        t_rgb  bg;
    } t_side;

endpackage

@@ sv/abl_div.sv @@
// Pipelined restoring divider: 16-bit numerator by 8-bit divisor, 8-bit quotient.
module abl_div (
    input  logic          i_clk,
    input  abl_pkg::t_num  i_num,
    input  abl_pkg::t_chan i_div,
    output abl_pkg::t_chan o_quo
);

    abl_pkg::t_num  r_rem [abl_pkg::DIV_STAGES-1];
    abl_pkg::t_chan r_dv  [abl_pkg::DIV_STAGES-1];
    abl_pkg::t_chan r_quo [abl_pkg::DIV_STAGES];

    for (genvar k = 0; k < abl_pkg::DIV_STAGES; k++) begin : g_stage
        abl_pkg::t_num  rem_in;
        abl_pkg::t_chan quo_in;
        abl_pkg::t_chan dv_in;
        abl_pkg::t_num  n_rem;
        abl_pkg::t_chan n_quo;

        if (k == 0) begin : g_first
            assign rem_in = i_num;
            assign quo_in = '0;
            assign dv_in  = i_div;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign quo_in = r_quo[k-1];
            assign dv_in  = r_dv[k-1];
        end

        always_comb begin
            abl_pkg::t_num trial;
            logic          ge;
            n_rem = rem_in;
            n_quo = quo_in;
            for (int j = 0; j < abl_pkg::DIV_BITS; j++) begin
                trial = abl_pkg::t_num'(dv_in)
                        << (abl_pkg::CHAN_W - 1 - k * abl_pkg::DIV_BITS - j);
                ge    = (n_rem >= trial);
                if (ge) begin
                    n_rem = n_rem - trial;
                end
                n_quo = {n_quo[abl_pkg::CHAN_W-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            r_quo[k] <= n_quo;
        end

        if (k < abl_pkg::DIV_STAGES - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[k] <= n_rem;
                r_dv[k]  <= dv_in;
            end
        end
    end

    assign o_quo = r_quo[abl_pkg::DIV_STAGES-1];

endmodule

@@ sv/additive_alpha_pixel_blend_top.sv @@
// Additive alpha pixel blend: top level with weight, product, divider and output stages.
//
// Usage:
//   Drive one foreground/background BGRA pixel pair on the i_fg_* and i_bg_*
//   ports and raise start; the pair transfers at the rising edge where start
//   is high and busy is low. busy is high only while reset is held, so one
//   pair can transfer in every clock cycle.
//   Each blended pixel appears on the o_out_* ports for exactly one cycle,
//   flagged by o_valid, after its pair has passed the register for the
//   saturated alpha and weights, the one for the weighted sums, the
//   divider stages (two quotient bits per stage) and the output register.
//   Throughput is one pixel per clock.
//   Results leave in transfer order and the receiver must take each one in
//   the cycle it is shown; there is no backpressure.
//   A synchronous reset (i_rst_n low) clears all valid bits, so any pixels
//   in flight are dropped and o_valid stays low until new pairs arrive.
//   When both alphas are zero the color channels pass the background.
module additive_alpha_pixel_blend_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] i_fg_blue,
    input  logic [7:0] i_fg_green,
    input  logic [7:0] i_fg_red,
    input  logic [7:0] i_fg_alpha,
    input  logic [7:0] i_bg_blue,
    input  logic [7:0] i_bg_green,
    input  logic [7:0] i_bg_red,
    input  logic [7:0] i_bg_alpha,
    output logic       o_valid,
    output logic [7:0] o_out_blue,
    output logic [7:0] o_out_green,
    output logic [7:0] o_out_red,
    output logic [7:0] o_out_alpha
);

    logic                   accept;
    logic [abl_pkg::CHAN_W:0] sum_alpha;

    abl_pkg::t_chan n_s1_da;
    abl_pkg::t_chan n_s1_wb;
    abl_pkg::t_rgb  n_s1_fg;
    abl_pkg::t_rgb  n_s1_bg;

    logic           r_s1_vld;
    abl_pkg::t_chan r_s1_fa;
    abl_pkg::t_chan r_s1_wb;
    abl_pkg::t_rgb  r_s1_fg;
    abl_pkg::t_side r_s1_side;

    abl_pkg::t_num  n_s2_num [abl_pkg::NCH];
    abl_pkg::t_num  r_s2_num [abl_pkg::NCH];
    logic           r_s2_vld;
    abl_pkg::t_side r_s2_side;

    logic           r_dp_vld  [abl_pkg::DIV_STAGES];
    abl_pkg::t_side r_dp_side [abl_pkg::DIV_STAGES];

    abl_pkg::t_chan quo [abl_pkg::NCH];
    abl_pkg::t_side last_side;
    abl_pkg::t_rgb  n_out_rgb;

    logic           r_out_vld;
    abl_pkg::t_rgb  r_out_rgb;
    abl_pkg::t_chan r_out_alpha;

    assign busy   = !i_rst_n;
    assign accept = start && !busy;

    assign sum_alpha = {1'b0, i_fg_alpha} + {1'b0, i_bg_alpha};
    assign n_s1_da   = sum_alpha[abl_pkg::CHAN_W] ? abl_pkg::ALPHA_MAX
                                                  : sum_alpha[abl_pkg::CHAN_W-1:0];
    assign n_s1_wb   = n_s1_da - i_fg_alpha;

    always_comb begin
        n_s1_fg[abl_pkg::CH_BLUE]  = i_fg_blue;
        n_s1_fg[abl_pkg::CH_GREEN] = i_fg_green;
        n_s1_fg[abl_pkg::CH_RED]   = i_fg_red;
        n_s1_bg[abl_pkg::CH_BLUE]  = i_bg_blue;
        n_s1_bg[abl_pkg::CH_GREEN] = i_bg_green;
        n_s1_bg[abl_pkg::CH_RED]   = i_bg_red;
    end

    always_ff @(posedge i_clk) begin
        r_s1_fa      <= i_fg_alpha;
        r_s1_wb      <= n_s1_wb;
        r_s1_fg      <= n_s1_fg;
        r_s1_side.da <= n_s1_da;
        r_s1_side.bg <= n_s1_bg;
    end

    always_comb begin
        for (int c = 0; c < abl_pkg::NCH; c++) begin
            n_s2_num[c] = abl_pkg::t_num'(r_s1_fg[c]) * abl_pkg::t_num'(r_s1_fa)
                        + abl_pkg::t_num'(r_s1_side.bg[c]) * abl_pkg::t_num'(r_s1_wb);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_num  <= n_s2_num;
        r_s2_side <= r_s1_side;
    end

    for (genvar c = 0; c < abl_pkg::NCH; c++) begin : g_chan
        abl_div u_div (
            .i_clk (i_clk),
            .i_num (r_s2_num[c]),
            .i_div (r_s2_side.da),
            .o_quo (quo[c])
        );
    end

    always_ff @(posedge i_clk) begin
        r_dp_side[0] <= r_s2_side;
        for (int k = 1; k < abl_pkg::DIV_STAGES; k++) begin
            r_dp_side[k] <= r_dp_side[k-1];
        end
    end

    assign last_side = r_dp_side[abl_pkg::DIV_STAGES-1];

    always_comb begin
        for (int c = 0; c < abl_pkg::NCH; c++) begin
            n_out_rgb[c] = (last_side.da == '0) ? last_side.bg[c] : quo[c];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_rgb   <= n_out_rgb;
        r_out_alpha <= last_side.da;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int k = 0; k < abl_pkg::DIV_STAGES; k++) begin
                r_dp_vld[k] <= 1'b0;
            end
        end else begin
            r_s1_vld    <= accept;
            r_s2_vld    <= r_s1_vld;
            r_dp_vld[0] <= r_s2_vld;
            for (int k = 1; k < abl_pkg::DIV_STAGES; k++) begin
                r_dp_vld[k] <= r_dp_vld[k-1];
            end
            r_out_vld <= r_dp_vld[abl_pkg::DIV_STAGES-1];
        end
    end

    assign o_valid     = r_out_vld;
    assign o_out_blue  = r_out_rgb[abl_pkg::CH_BLUE];
    assign o_out_green = r_out_rgb[abl_pkg::CH_GREEN];
    assign o_out_red   = r_out_rgb[abl_pkg::CH_RED];
    assign o_out_alpha = r_out_alpha;

    a_valid_follows_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, 7))
        else $error("result strobe without a matching transfer");

    a_alpha_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_alpha != abl_pkg::ALPHA_MAX) |->
        ({1'b0, o_out_alpha} == {1'b0, $past(i_fg_alpha, 7)} + {1'b0, $past(i_bg_alpha, 7)}))
        else $error("result alpha is not the sum of the input alphas");

    a_opaque_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_fg_alpha, 7) == abl_pkg::ALPHA_MAX) |->
        (o_out_blue == $past(i_fg_blue, 7) && o_out_red == $past(i_fg_red, 7)))
        else $error("opaque foreground not copied");

    a_zero_alpha_bg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_alpha == '0) |->
        (o_out_green == $past(i_bg_green, 7) && o_out_red == $past(i_bg_red, 7)))
        else $error("zero alpha did not pass the background");

endmodule

@@ dv/testbench.sv @@
// Testbench for the additive alpha pixel blend block: directed and random pixel pairs.
`timescale 1ns / 1ps

module testbench;

    localparam int RESULT_LATENCY = 7;
    localparam int QUIET_LIMIT    = 1000;

    typedef abl_pkg::t_chan t_chan;

    typedef struct packed {
        t_chan fg_blue;
        t_chan fg_green;
        t_chan fg_red;
        t_chan fg_alpha;
        t_chan bg_blue;
        t_chan bg_green;
        t_chan bg_red;
        t_chan bg_alpha;
    } t_pixel_pair;

    typedef struct packed {
        t_chan blue;
        t_chan green;
        t_chan red;
        t_chan alpha;
    } t_blend_px;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    t_chan i_fg_blue = '0;
    t_chan i_fg_green = '0;
    t_chan i_fg_red = '0;
    t_chan i_fg_alpha = '0;
    t_chan i_bg_blue = '0;
    t_chan i_bg_green = '0;
    t_chan i_bg_red = '0;
    t_chan i_bg_alpha = '0;
    logic  o_valid;
    t_chan o_out_blue;
    t_chan o_out_green;
    t_chan o_out_red;
    t_chan o_out_alpha;

    t_blend_px pending_blends[$];
    int        n_sent = 0;
    int        n_checked = 0;
    int        n_errors = 0;
    int        quiet_cycles = 0;
    int        send_gap_pct = 0;

    additive_alpha_pixel_blend_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_fg_blue  (i_fg_blue),
        .i_fg_green (i_fg_green),
        .i_fg_red   (i_fg_red),
        .i_fg_alpha (i_fg_alpha),
        .i_bg_blue  (i_bg_blue),
        .i_bg_green (i_bg_green),
        .i_bg_red   (i_bg_red),
        .i_bg_alpha (i_bg_alpha),
        .o_valid    (o_valid),
        .o_out_blue (o_out_blue),
        .o_out_green(o_out_green),
        .o_out_red  (o_out_red),
        .o_out_alpha(o_out_alpha)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_chan mix_channel(input t_chan fg, input t_chan bg,
                                          input t_chan fa, input t_chan da);
        logic [16:0] num;
        if (da == '0) begin
            return bg;
        end
        num = fg * fa + bg * (da - fa);
        return t_chan'(num / da);
    endfunction

    function automatic t_blend_px blend_pixel(input t_pixel_pair p);
        t_blend_px   r;
        logic [8:0]  alpha_sum;
        t_chan       da;
        alpha_sum = p.fg_alpha + p.bg_alpha;
        da = (alpha_sum > abl_pkg::ALPHA_MAX) ? abl_pkg::ALPHA_MAX : alpha_sum[7:0];
        r.blue  = mix_channel(p.fg_blue, p.bg_blue, p.fg_alpha, da);
        r.green = mix_channel(p.fg_green, p.bg_green, p.fg_alpha, da);
        r.red   = mix_channel(p.fg_red, p.bg_red, p.fg_alpha, da);
        r.alpha = da;
        return r;
    endfunction

    function automatic t_pixel_pair make_pair(input t_chan fb, input t_chan fgr,
                                              input t_chan fr, input t_chan fa,
                                              input t_chan bb, input t_chan bgr,
                                              input t_chan br, input t_chan ba);
        t_pixel_pair p;
        p = '{fb, fgr, fr, fa, bb, bgr, br, ba};
        return p;
    endfunction

    function automatic t_chan rand_color();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return 8'd0;
        end else if (pick == 1) begin
            return 8'd255;
        end
        return t_chan'($urandom);
    endfunction

    function automatic t_pixel_pair rand_pair();
        t_pixel_pair p;
        int          mode;
        p.fg_blue  = rand_color();
        p.fg_green = rand_color();
        p.fg_red   = rand_color();
        p.bg_blue  = rand_color();
        p.bg_green = rand_color();
        p.bg_red   = rand_color();
        mode = $urandom_range(0, 9);
        case (mode)
            0: begin
                p.fg_alpha = 8'd0;
                p.bg_alpha = 8'd0;
            end
            1: begin
                p.fg_alpha = 8'd255;
                p.bg_alpha = t_chan'($urandom);
            end
            2: begin
                p.fg_alpha = 8'd255;
                p.bg_alpha = 8'd255;
            end
            3: begin
                p.fg_alpha = t_chan'($urandom_range(0, 3));
                p.bg_alpha = t_chan'($urandom_range(0, 3));
            end
            4: begin
                p.fg_alpha = t_chan'($urandom);
                p.bg_alpha = t_chan'(255 - p.fg_alpha + $urandom_range(0, 2));
            end
            default: begin
                p.fg_alpha = t_chan'($urandom);
                p.bg_alpha = t_chan'($urandom);
            end
        endcase
        return p;
    endfunction

    task automatic report_error(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        n_errors++;
    endtask

    task automatic send_pair(input t_pixel_pair p);
        start      <= 1'b1;
        i_fg_blue  <= p.fg_blue;
        i_fg_green <= p.fg_green;
        i_fg_red   <= p.fg_red;
        i_fg_alpha <= p.fg_alpha;
        i_bg_blue  <= p.bg_blue;
        i_bg_green <= p.bg_green;
        i_bg_red   <= p.bg_red;
        i_bg_alpha <= p.bg_alpha;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_blends = {pending_blends, blend_pixel(p)};
        n_sent++;
        if ($urandom_range(0, 99) < send_gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < send_gap_pct) @(posedge i_clk);
        end
    endtask

    // hold off until every outstanding pixel has come back
    task automatic drain_pending();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_blends.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_random(input int count);
        repeat (count) send_pair(rand_pair());
        drain_pending();
    endtask

    task automatic test_edge_pixels();
        send_pair(make_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_pair(make_pair(8'd255, 8'd255, 8'd255, 8'd255,
                            8'd255, 8'd255, 8'd255, 8'd255));
        send_pair(make_pair(8'd12, 8'd200, 8'd255, 8'd0, 8'd77, 8'd1, 8'd254, 8'd0));
        send_pair(make_pair(8'd255, 8'd0, 8'd128, 8'd0, 8'd0, 8'd255, 8'd127, 8'd0));
        send_pair(make_pair(8'd10, 8'd20, 8'd30, 8'd255, 8'd90, 8'd80, 8'd70, 8'd0));
        send_pair(make_pair(8'd255, 8'd0, 8'd99, 8'd255, 8'd0, 8'd255, 8'd1, 8'd200));
        send_pair(make_pair(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255));
        send_pair(make_pair(8'd0, 8'd128, 8'd255, 8'd0, 8'd255, 8'd17, 8'd3, 8'd1));
        send_pair(make_pair(8'd255, 8'd255, 8'd255, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0));
        send_pair(make_pair(8'd255, 8'd254, 8'd1, 8'd1, 8'd0, 8'd3, 8'd200, 8'd1));
        send_pair(make_pair(8'd255, 8'd255, 8'd255, 8'd1, 8'd0, 8'd0, 8'd0, 8'd254));
        send_pair(make_pair(8'd200, 8'd100, 8'd50, 8'd128, 8'd10, 8'd20, 8'd30, 8'd127));
        send_pair(make_pair(8'd200, 8'd100, 8'd50, 8'd128, 8'd10, 8'd20, 8'd30, 8'd128));
        send_pair(make_pair(8'hAA, 8'h55, 8'hAA, 8'h55, 8'h55, 8'hAA, 8'h55, 8'hAA));
        send_pair(make_pair(8'h55, 8'hAA, 8'h55, 8'hAA, 8'hAA, 8'h55, 8'hAA, 8'h55));
        send_pair(make_pair(8'd0, 8'd0, 8'd0, 8'd254, 8'd255, 8'd255, 8'd255, 8'd1));
        send_pair(make_pair(8'd255, 8'd255, 8'd255, 8'd2, 8'd254, 8'd254, 8'd254, 8'd3));
        drain_pending();
    endtask

    task automatic test_light_gaps();
        send_gap_pct = 13;
        run_random(130);
    endtask

    task automatic test_heavy_gaps();
        send_gap_pct = 46;
        run_random(130);
    endtask

    task automatic test_back_to_back();
        send_gap_pct = 0;
        run_random(140);
    endtask

    always @(posedge i_clk) begin
        t_blend_px want;
        if (i_rst_n && o_valid) begin
            if (pending_blends.size() == 0) begin
                report_error($sformatf("unexpected pixel b=%0d g=%0d r=%0d a=%0d",
                             o_out_blue, o_out_green, o_out_red, o_out_alpha));
            end else begin
                want = pending_blends.pop_front();
                if (o_out_blue !== want.blue)
                    report_error($sformatf("pixel %0d blue got %0d want %0d",
                                 n_checked, o_out_blue, want.blue));
                if (o_out_green !== want.green)
                    report_error($sformatf("pixel %0d green got %0d want %0d",
                                 n_checked, o_out_green, want.green));
                if (o_out_red !== want.red)
                    report_error($sformatf("pixel %0d red got %0d want %0d",
                                 n_checked, o_out_red, want.red));
                if (o_out_alpha !== want.alpha)
                    report_error($sformatf("pixel %0d alpha got %0d want %0d",
                                 n_checked, o_out_alpha, want.alpha));
                n_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_edge_pixels();
        test_light_gaps();
        test_heavy_gaps();
        test_back_to_back();
        repeat (RESULT_LATENCY + 3) @(posedge i_clk);
        if (pending_blends.size() != 0)
            report_error($sformatf("%0d pixels never came back", pending_blends.size()));
        $display("covered %0d pixel pairs: edge and zero alphas, opaque and saturated sums,",
                 n_sent);
        $display("sparse, dense and back-to-back transfers; %0d results checked", n_checked);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/abl_pkg.sv
sv/abl_div.sv
sv/additive_alpha_pixel_blend_top.sv
dv/testbench.sv
